### design/wgm_pkg.sv
// Package for the wildcard glob matcher: request kinds, wildcard bytes and the
// control bundle broadcast along the row of position cells. No dependencies.
package wgm_pkg;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_CHAR   = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUEST = 8'h3F;

	// Control broadcast to every cell for one accepted request.
	typedef struct packed {
		logic step;     // subject character: advance the active positions
		logic restart;  // back to only position zero active
	} wgm_ctrl_t;

endpackage

### design/wildcard_glob_matcher.sv
// Wildcard glob matcher: a row of MAX_PATTERN position cells plus one end position.
// Every request (append, clear, subject byte, end of line) is handled when accepted;
// one request per cycle unless a held result stalls the input. The end of line result
// is registered, on the master side in the cycle after its request, held until taken.
// Asynchronous reset empties the pattern, clears the overflow flag and leaves only
// position zero active. Depends on wgm_pkg and wgm_cell.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic [1:0] s_tuser,   // [1:0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

	localparam int LenW = $clog2(MAX_PATTERN + 1);

	// Raw length counts every byte appended, for the overflow limit. The cells
	// hold the pattern with each run of stars folded into one star, which
	// matches the same lines; cell_len_q counts those stored cells.
	logic [LenW-1:0] raw_len_q;
	logic [LenW-1:0] cell_len_q;
	logic            last_star_q;
	logic            overflow_q;
	logic            tail_active_q;   // the position past the last cell
	logic            m_tvalid_q;
	logic            matched_s1;
	logic            overflow_s1;

	logic            accept;
	logic            do_append;
	logic            do_clear;
	logic            do_end;
	logic            ch_is_star;
	logic            full;
	logic            store;
	wgm_pkg::wgm_ctrl_t ctrl;

	logic [MAX_PATTERN-1:0] star_chain;
	logic [MAX_PATTERN-1:0] adv_chain;
	logic [MAX_PATTERN:0]   closed_all;
	logic [MAX_PATTERN:0]   at_end;
	logic                   line_match;

	// The result register parts the two sides: a new request is taken whenever
	// the slot is free or its result leaves in this cycle.
	assign s_tready  = ~m_tvalid_q | m_tready;
	assign accept    = s_tvalid & s_tready;
	assign do_append = accept & (s_tuser == wgm_pkg::KIND_APPEND);
	assign do_clear  = accept & (s_tuser == wgm_pkg::KIND_CLEAR);
	assign do_end    = accept & (s_tuser == wgm_pkg::KIND_END);
	assign ch_is_star = (s_tdata == wgm_pkg::CH_STAR);
	assign full      = (raw_len_q == LenW'(MAX_PATTERN));
	// A star that follows a stored star adds nothing to the cells.
	assign store     = do_append & ~full & ~(ch_is_star & last_star_q);

	// Any pattern edit and every end of line start a fresh subject.
	assign ctrl.step    = accept & (s_tuser == wgm_pkg::KIND_CHAR);
	assign ctrl.restart = do_append | do_clear | do_end;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic star_prev;
		logic adv_prev;
		if (i == 0) begin : g_head
			assign star_prev = 1'b0;
			assign adv_prev  = 1'b0;
		end else begin : g_body
			assign star_prev = star_chain[i-1];
			assign adv_prev  = adv_chain[i-1];
		end
		wgm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.home     ((i == 0) ? 1'b1 : 1'b0),
			.ctrl     (ctrl),
			.ch       (s_tdata),
			.wr_en    (store & (cell_len_q == LenW'(i))),
			.wr_char  (s_tdata),
			.in_use   (LenW'(i) < cell_len_q),
			.star_in  (star_prev),
			.adv_in   (adv_prev),
			.star_out (star_chain[i]),
			.adv_out  (adv_chain[i]),
			.closed   (closed_all[i])
		);
		assign at_end[i] = (cell_len_q == LenW'(i));
	end

	assign closed_all[MAX_PATTERN] = tail_active_q | star_chain[MAX_PATTERN-1];
	assign at_end[MAX_PATTERN]     = (cell_len_q == LenW'(MAX_PATTERN));
	// The line matched when the position just past the stored pattern is reachable.
	assign line_match = |(closed_all & at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_len_q     <= '0;
			cell_len_q    <= '0;
			last_star_q   <= 1'b0;
			overflow_q    <= 1'b0;
			tail_active_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (do_clear) begin
				raw_len_q   <= '0;
				cell_len_q  <= '0;
				last_star_q <= 1'b0;
				overflow_q  <= 1'b0;
			end else if (do_append) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					raw_len_q <= raw_len_q + LenW'(1);
				end
				if (store) begin
					cell_len_q  <= cell_len_q + LenW'(1);
					last_star_q <= ch_is_star;
				end
			end
			if (ctrl.restart) begin
				tail_active_q <= 1'b0;
			end else if (ctrl.step) begin
				tail_active_q <= adv_chain[MAX_PATTERN-1];
			end
			if (do_end) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			matched_s1  <= line_match;
			overflow_s1 <= overflow_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, overflow_s1, matched_s1};

endmodule

### design/wgm_cell.sv
// One pattern position of the glob matcher row: holds one pattern byte and the
// active bit of its position, and trades closure and advance bits with its neighbours.
// Depends on wgm_pkg.
module wgm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              home,        // position zero: active after a restart
	input  wgm_pkg::wgm_ctrl_t ctrl,
	input  logic [7:0]        ch,          // subject byte of a step
	input  logic              wr_en,       // store a pattern byte in this cell
	input  logic [7:0]        wr_char,
	input  logic              in_use,      // cell lies inside the stored pattern
	input  logic              star_in,     // active star in the previous cell
	input  logic              adv_in,      // previous cell consumed the byte
	output logic              star_out,
	output logic              adv_out,
	output logic              closed
);

	logic [7:0] char_q;
	logic       active_q;
	logic       is_star;
	logic       hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			char_q <= wr_char;
		end
	end

	assign is_star  = (char_q == wgm_pkg::CH_STAR);
	// Star runs are stored collapsed, so a star reached through the previous cell
	// can never itself be preceded by another star: one hop is the whole closure.
	assign closed   = active_q | star_in;
	assign star_out = active_q & in_use & is_star;
	assign hit      = (char_q == wgm_pkg::CH_QUEST) | (char_q == ch);
	assign adv_out  = closed & in_use & ~is_star & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= home;
		end else if (ctrl.restart) begin
			active_q <= home;
		end else if (ctrl.step) begin
			active_q <= (closed & in_use & is_star) | adv_in;
		end
	end

endmodule

### design/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to its top level.
// Depends on wgm_pkg.
module wgm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic acc_end;
	logic acc_clear;

	assign acc_end   = s_tvalid & s_tready & (s_tuser == wgm_pkg::KIND_END);
	assign acc_clear = s_tvalid & s_tready & (s_tuser == wgm_pkg::KIND_CLEAR);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_result_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc_end |=> m_tvalid)
		else $error("end of line gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(acc_end))
		else $error("result without an end of line request");

	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		acc_clear ##1 acc_end |=> m_tdata[0] && !m_tdata[1])
		else $error("empty pattern must match an empty line without overflow");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'd0))
		else $error("result padding bits not zero");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
